>>> rtl/fifo_order_matcher_defines.svh
// ----------------------------------------------------------------------------
// fifo_order_matcher_defines
// Assertion macros used by the order matcher back end.
// ----------------------------------------------------------------------------
`ifndef FIFO_ORDER_MATCHER_DEFINES_SVH
`define FIFO_ORDER_MATCHER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define FOM_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define FOM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/fom_pkg.sv
// ----------------------------------------------------------------------------
// fom_pkg
// Types and codes shared by the order matcher front end, back end and top.
// ----------------------------------------------------------------------------
`default_nettype none

package fom_pkg;

    localparam int PRICE_W = 32;
    localparam int VOL_W   = 31;

    localparam int MAX_TRADES  = 32;
    localparam int TRADE_CNT_W = $clog2(MAX_TRADES + 1);

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_MATCH = 1'b1;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    localparam logic [2:0] KIND_ADDED = 3'd0;
    localparam logic [2:0] KIND_FULL  = 3'd1;
    localparam logic [2:0] KIND_ZERO  = 3'd2;
    localparam logic [2:0] KIND_TRADE = 3'd3;
    localparam logic [2:0] KIND_NONE  = 3'd4;

    // Command classes produced by the front end
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_ZERO  = 2'd1;
    localparam logic [1:0] CMD_MATCH = 2'd2;

    typedef struct packed {
        logic               opcode;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [VOL_W-1:0]   volume;
    } item_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [VOL_W-1:0]   trade_volume;
        logic [PRICE_W-1:0] trade_price;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [1:0]         code;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [VOL_W-1:0]   volume;
    } cmd_t;

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [VOL_W-1:0]   volume;
    } entry_t;

endpackage

`default_nettype wire

>>> rtl/fom_front.sv
// ----------------------------------------------------------------------------
// fom_front
// Accepts command items, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module fom_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_stall,
    input  wire fom_pkg::item_t cmd,
    output logic                q_valid,
    input  wire logic           q_pop,
    output fom_pkg::cmd_t       q_cmd
);
    import fom_pkg::*;

    cmd_t       entry_reg [2];
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    cmd_t       push_cmd;

    always_comb
    begin
        push_cmd.side   = cmd.side;
        push_cmd.price  = cmd.price;
        push_cmd.volume = cmd.volume;
        if (cmd.opcode == OP_MATCH)
        begin
            push_cmd.code = CMD_MATCH;
        end
        else if (cmd.volume == '0)
        begin
            push_cmd.code = CMD_ZERO;
        end
        else
        begin
            push_cmd.code = CMD_ADD;
        end
    end

    assign cmd_stall = (cnt_reg == 2'd2);
    assign push      = cmd_valid && !cmd_stall;
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_cmd     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (q_pop && q_valid)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !(q_pop && q_valid))
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!push && q_pop && q_valid)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> rtl/fom_back.sv
// ----------------------------------------------------------------------------
// fom_back
// Executes queued commands against the buy and sell queues and walks the
// book heads for matching, one trade per S_LOAD / S_CMP pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fifo_order_matcher_defines.svh"

module fom_back #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    output logic               q_pop,
    input  wire fom_pkg::cmd_t q_cmd,
    output logic               res_valid,
    input  wire logic          res_stall,
    output fom_pkg::result_t   res
);
    import fom_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(QUEUE_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_S   = SUM_W'(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [TRADE_CNT_W-1:0] TRADE_LIMIT = TRADE_CNT_W'(MAX_TRADES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [IDX_W-1:0]       buy_head_reg, buy_head_next;
    logic [IDX_W-1:0]       sell_head_reg, sell_head_next;
    logic [CNT_W-1:0]       buy_count_reg, buy_count_next;
    logic [CNT_W-1:0]       sell_count_reg, sell_count_next;
    logic [TRADE_CNT_W-1:0] trades_reg, trades_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [VOL_W-1:0]       pend_vol_reg, pend_vol_next;
    logic [PRICE_W-1:0]     pend_price_reg, pend_price_next;
    logic                   res_valid_reg, res_valid_next;
    result_t                res_reg, res_next;

    entry_t           buy_mem [QUEUE_DEPTH];
    entry_t           sell_mem [QUEUE_DEPTH];
    entry_t           buy_rd_reg;
    entry_t           sell_rd_reg;
    logic             buy_we, sell_we;
    logic [IDX_W-1:0] buy_waddr, sell_waddr;
    entry_t           buy_wdata, sell_wdata;

    logic             emit_ok;
    logic [IDX_W-1:0] add_head;
    logic [CNT_W-1:0] add_count;
    logic [SUM_W-1:0] tail_sum;
    logic [IDX_W-1:0] tail_idx;
    logic             add_full;
    logic             crossed;
    logic [VOL_W-1:0] trade_vol;
    logic [VOL_W-1:0] buy_rem;
    logic [VOL_W-1:0] sell_rem;
    entry_t           add_entry;

    assign emit_ok = !res_valid_reg || !res_stall;

    // Tail slot of the side being added to
    assign add_head  = (q_cmd.side == SIDE_SELL) ? sell_head_reg : buy_head_reg;
    assign add_count = (q_cmd.side == SIDE_SELL) ? sell_count_reg : buy_count_reg;
    assign tail_sum  = SUM_W'(add_head) + SUM_W'(add_count);
    assign tail_idx  = (tail_sum >= DEPTH_S) ? IDX_W'(tail_sum - DEPTH_S) : IDX_W'(tail_sum);
    assign add_full  = (add_count == DEPTH_C);
    assign add_entry = '{price: q_cmd.price, volume: q_cmd.volume};

    assign crossed   = (buy_rd_reg.price >= sell_rd_reg.price);
    assign trade_vol = (buy_rd_reg.volume < sell_rd_reg.volume) ? buy_rd_reg.volume
                                                                : sell_rd_reg.volume;
    assign buy_rem   = buy_rd_reg.volume - trade_vol;
    assign sell_rem  = sell_rd_reg.volume - trade_vol;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        next_idx = (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
    endfunction

    always_comb
    begin
        state_next      = state_reg;
        buy_head_next   = buy_head_reg;
        sell_head_next  = sell_head_reg;
        buy_count_next  = buy_count_reg;
        sell_count_next = sell_count_reg;
        trades_next     = trades_reg;
        pend_valid_next = pend_valid_reg;
        pend_vol_next   = pend_vol_reg;
        pend_price_next = pend_price_reg;
        res_valid_next  = res_valid_reg && res_stall;
        res_next        = res_reg;
        q_pop           = 1'b0;
        buy_we          = 1'b0;
        sell_we         = 1'b0;
        buy_waddr       = tail_idx;
        sell_waddr      = tail_idx;
        buy_wdata       = add_entry;
        sell_wdata      = add_entry;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_cmd.code)
                        CMD_ZERO:
                        begin
                            if (emit_ok)
                            begin
                                q_pop          = 1'b1;
                                res_valid_next = 1'b1;
                                res_next       = '{KIND_ZERO, '0, '0, 1'b1};
                            end
                        end
                        CMD_ADD:
                        begin
                            if (emit_ok)
                            begin
                                q_pop          = 1'b1;
                                res_valid_next = 1'b1;
                                if (add_full)
                                begin
                                    res_next = '{KIND_FULL, '0, '0, 1'b1};
                                end
                                else
                                begin
                                    res_next = '{KIND_ADDED, '0, '0, 1'b1};
                                    if (q_cmd.side == SIDE_SELL)
                                    begin
                                        sell_we         = 1'b1;
                                        sell_count_next = sell_count_reg + CNT_W'(1);
                                    end
                                    else
                                    begin
                                        buy_we         = 1'b1;
                                        buy_count_next = buy_count_reg + CNT_W'(1);
                                    end
                                end
                            end
                        end
                        CMD_MATCH:
                        begin
                            q_pop           = 1'b1;
                            trades_next     = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_LOAD;
                        end
                        default:
                        begin
                            // drop a code that means nothing
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                // head entries are read this cycle; compare next cycle
                if (buy_count_reg != '0 && sell_count_reg != '0 && trades_reg != TRADE_LIMIT)
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_CMP:
            begin
                if (!crossed)
                begin
                    state_next = S_FIN;
                end
                else if (!pend_valid_reg || emit_ok)
                begin
                    // release the previous trade, hold this one until the next is known
                    if (pend_valid_reg)
                    begin
                        res_valid_next = 1'b1;
                        res_next       = '{KIND_TRADE, pend_vol_reg, pend_price_reg, 1'b0};
                    end
                    pend_valid_next = 1'b1;
                    pend_vol_next   = trade_vol;
                    pend_price_next = sell_rd_reg.price;
                    trades_next     = trades_reg + TRADE_CNT_W'(1);
                    buy_we          = 1'b1;
                    buy_waddr       = buy_head_reg;
                    buy_wdata       = '{price: buy_rd_reg.price, volume: buy_rem};
                    sell_we         = 1'b1;
                    sell_waddr      = sell_head_reg;
                    sell_wdata      = '{price: sell_rd_reg.price, volume: sell_rem};
                    if (buy_rem == '0)
                    begin
                        buy_head_next  = next_idx(buy_head_reg);
                        buy_count_next = buy_count_reg - CNT_W'(1);
                    end
                    if (sell_rem == '0)
                    begin
                        sell_head_next  = next_idx(sell_head_reg);
                        sell_count_next = sell_count_reg - CNT_W'(1);
                    end
                    state_next = S_LOAD;
                end
            end
            S_FIN:
            begin
                if (emit_ok)
                begin
                    res_valid_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        res_next = '{KIND_TRADE, pend_vol_reg, pend_price_reg, 1'b1};
                    end
                    else
                    begin
                        res_next = '{KIND_NONE, '0, '0, 1'b1};
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            buy_head_reg   <= '0;
            sell_head_reg  <= '0;
            buy_count_reg  <= '0;
            sell_count_reg <= '0;
            trades_reg     <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            buy_head_reg   <= buy_head_next;
            sell_head_reg  <= sell_head_next;
            buy_count_reg  <= buy_count_next;
            sell_count_reg <= sell_count_next;
            trades_reg     <= trades_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_vol_reg   <= pend_vol_next;
        pend_price_reg <= pend_price_next;
        res_reg        <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (buy_we)
        begin
            buy_mem[buy_waddr] <= buy_wdata;
        end
        buy_rd_reg <= buy_mem[buy_head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (sell_we)
        begin
            sell_mem[sell_waddr] <= sell_wdata;
        end
        sell_rd_reg <= sell_mem[sell_head_reg];
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `FOM_ASSERT(a_buy_count_bound, 1'b1, buy_count_reg <= DEPTH_C, "buy queue overfilled")
    `FOM_ASSERT(a_sell_count_bound, 1'b1, sell_count_reg <= DEPTH_C, "sell queue overfilled")
    `FOM_ASSERT(a_trade_bound, 1'b1, trades_reg <= TRADE_LIMIT, "too many trades in one match")
    `FOM_ASSERT(a_idle_no_pend, state_reg == S_IDLE, !pend_valid_reg, "trade left pending in idle")
    `FOM_ASSERT(a_trade_nonzero, res_valid_reg && res_reg.kind == KIND_TRADE, res_reg.trade_volume != '0, "trade of zero volume")
    `FOM_ASSERT_NEXT(a_match_starts, state_reg == S_IDLE && q_valid && q_cmd.code == CMD_MATCH, state_reg == S_LOAD && trades_reg == '0, "match did not start cleanly")

endmodule

`default_nettype wire

>>> rtl/fifo_order_matcher.sv
// ----------------------------------------------------------------------------
// fifo_order_matcher
// One-instrument order book with buy and sell arrival-ordered queues.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) takes add and match commands.
//   res channel (res_valid / res_stall / res) returns one result per add and
//   one result per trade of a match (or a single no-trade result); the last
//   result of each command carries last = 1.
// Sequencing:
//   Commands pass a two-entry queue into the executing sequencer. An add or
//   refused add is handled in the idle state; its result shows the cycle after.
//   A match trades step by step (head read from the queue memories in
//   S_LOAD, then compare and write back in S_CMP), after a start in the
//   idle state, and closes in S_FIN once a queue is empty, the heads stop
//   crossing or 32 trades are done: at most 32 trades per match.
//   The memory read of the head entries sets the S_LOAD / S_CMP trade step.
// Reset:
//   Both queues are empty after reset; no clearing pass is needed.
// Stalls:
//   A stalled result holds in the output register; the sequencer waits and
//   commands collect in the queue until it is full, then cmd_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_order_matcher #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    output logic                  cmd_stall,
    input  wire fom_pkg::item_t   cmd,
    output logic                  res_valid,
    input  wire logic             res_stall,
    output fom_pkg::result_t      res
);
    import fom_pkg::*;

    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    fom_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd)
    );

    fom_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

`default_nettype wire
